### hw/rtl/rks80_pkg.sv
// Shared types, constants and round function for the RECTANGLE-80 key schedule.
`timescale 1ns / 1ps

package rks80_pkg;

  localparam int ROUND_COUNT = 25;
  localparam int RND_W       = 5;
  localparam int ROW_W       = 16;
  localparam int FIFO_DEPTH  = 2;

  localparam logic [RND_W-1:0] ROUND_LAST = RND_W'(ROUND_COUNT);
  localparam logic [RND_W-1:0] RC_INIT    = RND_W'(1);

  typedef struct packed {
    logic [63:0]      rows_low;
    logic [ROW_W-1:0] row_top;
  } key_word_t;

  // Queue head as seen by the round engine.
  typedef struct packed {
    logic      valid;
    key_word_t key;
  } key_head_t;

  typedef logic [ROW_W-1:0] row_t;
  typedef row_t [4:0]       key_rows_t;

  localparam logic [3:0] SBOX [16] = '{
    4'h6, 4'h5, 4'hC, 4'hA, 4'h1, 4'hE, 4'h7, 4'h9,
    4'hB, 4'h0, 4'h3, 4'hD, 4'h8, 4'hF, 4'h4, 4'h2
  };

  function automatic row_t rotl(input row_t v, input int s);
    row_t res;
    res = (v << s) | (v >> (ROW_W - s));
    return res;
  endfunction

  function automatic logic [RND_W-1:0] lfsr_step(input logic [RND_W-1:0] rc);
    logic [RND_W-1:0] res;
    res = {rc[3:0], rc[4] ^ rc[2]};
    return res;
  endfunction

  // One round update: S-box on columns 0..3, row mixing, round constant.
  function automatic key_rows_t round_update(input key_rows_t k,
                                             input logic [RND_W-1:0] rc);
    key_rows_t  s;
    key_rows_t  m;
    logic [3:0] nib;
    logic [3:0] sub;
    s = k;
    for (int col = 0; col < 4; col++) begin
      nib = {k[3][col], k[2][col], k[1][col], k[0][col]};
      sub = SBOX[nib];
      for (int r = 0; r < 4; r++) begin
        s[r][col] = sub[r];
      end
    end
    m[0] = rotl(s[0], 8) ^ s[1];
    m[1] = s[2];
    m[2] = s[3];
    m[3] = rotl(s[3], 12) ^ s[4];
    m[4] = s[0];
    m[0] = m[0] ^ {{(ROW_W-RND_W){1'b0}}, rc};
    return m;
  endfunction

endpackage

### hw/rtl/rks80_key_fifo.sv
// Front end: two-entry queue of master keys ahead of the round engine.
`timescale 1ns / 1ps

module rks80_key_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  rks80_pkg::key_word_t in_key,
  output rks80_pkg::key_head_t head,
  input  logic                take
);

  rks80_pkg::key_word_t mem_r [rks80_pkg::FIFO_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full       = (count_r == 2'(rks80_pkg::FIFO_DEPTH));
  assign do_push    = push && !full;
  assign do_pop     = take && (count_r != 2'd0);
  assign head.valid = (count_r != 2'd0);
  assign head.key   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= in_key;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'(rks80_pkg::FIFO_DEPTH))
    else $error("key queue count overflow");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0 || count_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("key queue pointers disagree with count");

  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> head.valid)
    else $error("key taken from empty queue");

endmodule

### hw/rtl/rks80_round_engine.sv
// Back end: runs the round update, one round key word per cycle unless pop stalls, into an output word register.
`timescale 1ns / 1ps

module rks80_round_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rks80_pkg::key_head_t head,
  output logic                 take,
  output logic                 empty,
  input  logic                 pop,
  output logic [63:0]          round_key,
  output logic [rks80_pkg::RND_W-1:0] round_index,
  output logic                 last_key
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_r, state_nxt;
  rks80_pkg::key_rows_t         rows_r, rows_nxt;
  logic [rks80_pkg::RND_W-1:0]  cnt_r, cnt_nxt;
  logic [rks80_pkg::RND_W-1:0]  rc_r, rc_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [63:0]                  out_key_r;
  logic [rks80_pkg::RND_W-1:0]  out_idx_r;
  logic                         out_last_r;
  logic                         advance, emit, at_last, load;

  assign advance = !out_valid_r || pop;
  assign at_last = (cnt_r == rks80_pkg::ROUND_LAST);
  assign emit    = advance && (state_r == ST_RUN);
  // Load a new key when idle, or right behind the final word of a run.
  assign load    = advance && head.valid && ((state_r == ST_IDLE) || at_last);
  assign take    = load;

  always_comb begin
    state_nxt     = state_r;
    rows_nxt      = rows_r;
    cnt_nxt       = cnt_r;
    rc_nxt        = rc_r;
    out_valid_nxt = out_valid_r && !pop;
    if (emit) begin
      out_valid_nxt = 1'b1;
      rows_nxt      = rks80_pkg::round_update(rows_r, rc_r);
      rc_nxt        = rks80_pkg::lfsr_step(rc_r);
      cnt_nxt       = cnt_r + 1'b1;
      if (at_last) begin
        state_nxt = ST_IDLE;
      end
    end
    if (load) begin
      state_nxt = ST_RUN;
      rows_nxt  = {head.key.row_top, head.key.rows_low};
      cnt_nxt   = '0;
      rc_nxt    = rks80_pkg::RC_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rc_r        <= rks80_pkg::RC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rc_r        <= rc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rows_r <= rows_nxt;
    if (emit) begin
      out_key_r  <= {rows_r[3], rows_r[2], rows_r[1], rows_r[0]};
      out_idx_r  <= cnt_r;
      out_last_r <= at_last;
    end
  end

  assign empty       = !out_valid_r;
  assign round_key   = out_key_r;
  assign round_index = out_idx_r;
  assign last_key    = out_last_r;

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_idx_r == rks80_pkg::ROUND_LAST))
    else $error("last word carries wrong round index");

  a_rc_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    rc_r != '0)
    else $error("round constant register stuck at zero");

  a_run_step: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !at_last) |=> (cnt_r == $past(cnt_r) + 1'b1) && (state_r == ST_RUN))
    else $error("round counter failed to advance");

  a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (cnt_r == '0) && (rc_r == rks80_pkg::RC_INIT))
    else $error("new key did not restart schedule");

endmodule

### hw/rtl/rectangle80_key_schedule_unit.sv
// A loaded key goes first into the round-state register rows_r, then into the output register.
// Throughput: one round key word per cycle while pop keeps up, 26 words per master key, back to back;
// the next key loads in the cycle that emits the final word of the current run.
// A two-entry key queue takes new keys while the engine runs.
// Reset: synchronous active-low rst_n empties the queue and the output register.
`timescale 1ns / 1ps

module rectangle80_key_schedule_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [63:0] in_key_rows_low,
  input  logic [15:0] in_key_row_top,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] out_round_key,
  output logic [4:0]  out_round_index,
  output logic        out_last_key
);

  rks80_pkg::key_word_t in_key;
  rks80_pkg::key_head_t head;
  logic                 take;

  assign in_key.rows_low = in_key_rows_low;
  assign in_key.row_top  = in_key_row_top;

  rks80_key_fifo u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .in_key (in_key),
    .head   (head),
    .take   (take)
  );

  rks80_round_engine u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .take        (take),
    .empty       (empty),
    .pop         (pop),
    .round_key   (out_round_key),
    .round_index (out_round_index),
    .last_key    (out_last_key)
  );

endmodule

### tb/rectangle80_key_schedule_unit_tb.sv
// Testbench for the RECTANGLE-80 key schedule unit: directed and random keys, random stalls, scoreboard check.
`timescale 1ns / 1ps

module rectangle80_key_schedule_unit_tb;

  typedef struct {
    logic [63:0] round_key;
    logic [4:0]  round_index;
    logic        last_key;
  } round_key_word_t;

  class round_key_scoreboard;
    round_key_word_t pending_round_keys[$];
    logic [15:0]     sched_rows[5];
    logic [4:0]      sched_rc;
    int              mismatches = 0;

    function logic [3:0] subst_nibble(input logic [3:0] x);
      case (x)
        4'h0: return 4'h6;  4'h1: return 4'h5;  4'h2: return 4'hC;  4'h3: return 4'hA;
        4'h4: return 4'h1;  4'h5: return 4'hE;  4'h6: return 4'h7;  4'h7: return 4'h9;
        4'h8: return 4'hB;  4'h9: return 4'h0;  4'hA: return 4'h3;  4'hB: return 4'hD;
        4'hC: return 4'h8;  4'hD: return 4'hF;  4'hE: return 4'h4;  default: return 4'h2;
      endcase
    endfunction

    function void advance_round();
      logic [3:0]  nib;
      logic [15:0] r0;
      for (int col = 0; col < 4; col++) begin
        nib = {sched_rows[3][col], sched_rows[2][col], sched_rows[1][col], sched_rows[0][col]};
        nib = subst_nibble(nib);
        for (int k = 0; k < 4; k++) sched_rows[k][col] = nib[k];
      end
      r0            = sched_rows[0];
      sched_rows[0] = {r0[7:0], r0[15:8]} ^ sched_rows[1];
      sched_rows[1] = sched_rows[2];
      sched_rows[2] = sched_rows[3];
      sched_rows[3] = {sched_rows[3][3:0], sched_rows[3][15:4]} ^ sched_rows[4];
      sched_rows[4] = r0;
      sched_rows[0][4:0] = sched_rows[0][4:0] ^ sched_rc;
      sched_rc = {sched_rc[3:0], sched_rc[4] ^ sched_rc[2]};
    endfunction

    // Expand one accepted master key into its full list of round keys.
    function void log_master_key(input logic [63:0] rows_low, input logic [15:0] row_top);
      round_key_word_t w;
      for (int k = 0; k < 4; k++) sched_rows[k] = rows_low[16*k +: 16];
      sched_rows[4] = row_top;
      sched_rc      = 5'd1;
      for (int r = 0; r <= rks80_pkg::ROUND_COUNT; r++) begin
        if (r > 0) advance_round();
        w.round_key   = {sched_rows[3], sched_rows[2], sched_rows[1], sched_rows[0]};
        w.round_index = 5'(r);
        w.last_key    = (r == rks80_pkg::ROUND_COUNT);
        pending_round_keys.push_back(w);
      end
    endfunction

    function void check_round_key(input logic [63:0] key, input logic [4:0] idx,
                                  input logic last);
      round_key_word_t w;
      if (pending_round_keys.size() == 0) begin
        $error("unexpected word: round_key %h round_index %0d last_key %b", key, idx, last);
        mismatches++;
        return;
      end
      w = pending_round_keys.pop_front();
      if (key !== w.round_key) begin
        $error("round_key: expected %h, actual %h", w.round_key, key);
        mismatches++;
      end
      if (idx !== w.round_index) begin
        $error("round_index: expected %0d, actual %0d", w.round_index, idx);
        mismatches++;
      end
      if (last !== w.last_key) begin
        $error("last_key: expected %b, actual %b", w.last_key, last);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [63:0] in_key_rows_low = '0;
  logic [15:0] in_key_row_top = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [63:0] out_round_key;
  logic [4:0]  out_round_index;
  logic        out_last_key;

  round_key_scoreboard sb = new();
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;

  rectangle80_key_schedule_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_key_rows_low (in_key_rows_low),
    .in_key_row_top  (in_key_row_top),
    .empty           (empty),
    .pop             (pop),
    .out_round_key   (out_round_key),
    .out_round_index (out_round_index),
    .out_last_key    (out_last_key)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic send_master_key(input logic [63:0] rows_low, input logic [15:0] row_top);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_burst = ~tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 10);
    repeat (gap) begin
      @(negedge clk);
      push = 1'b0;
    end
    @(negedge clk);
    push            = 1'b1;
    in_key_rows_low = rows_low;
    in_key_row_top  = row_top;
    do @(posedge clk); while (full);
    sb.log_master_key(rows_low, row_top);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Result side: random stall before each word, bursts of back-to-back pops.
  initial begin
    int gap;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 199) == 0) rx_burst = ~rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, 10);
      repeat (gap) begin
        @(negedge clk);
        pop = 1'b0;
      end
      @(negedge clk);
      pop = 1'b1;
      do @(posedge clk); while (empty);
      sb.check_round_key(out_round_key, out_round_index, out_last_key);
    end
  end

  initial begin
    logic [63:0] lo;
    logic [15:0] hi;
    int          style;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Field extremes and simple bit patterns
    send_master_key('0, '0);
    send_master_key('1, '1);
    send_master_key('1, '0);
    send_master_key('0, '1);
    send_master_key(64'hAAAA_AAAA_AAAA_AAAA, 16'hAAAA);
    send_master_key(64'h5555_5555_5555_5555, 16'h5555);
    for (int k = 0; k < 4; k++) send_master_key(64'hFFFF << (16 * k), 16'h0000);
    send_master_key(64'h1, 16'h0000);
    send_master_key(64'h0, 16'h8000);
    send_master_key(64'h8000_0000_0000_0000, 16'h0001);
    send_master_key(64'h0123_4567_89AB_CDEF, 16'hFEDC);

    for (int n = 0; n < 420; n++) begin
      style = $urandom_range(0, 7);
      lo    = rand64();
      hi    = 16'($urandom());
      // Mix in sparse and dense keys to stress the S-box columns
      if (style == 0) begin
        lo = lo & rand64() & rand64();
        hi = hi & 16'($urandom()) & 16'($urandom());
      end else if (style == 1) begin
        lo = lo | rand64() | rand64();
        hi = hi | 16'($urandom()) | 16'($urandom());
      end
      send_master_key(lo, hi);
    end
    @(negedge clk);
    push = 1'b0;

    while (sb.pending_round_keys.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
